### hdl/reachable_event_chain_dp_macros.svh
// Assertion macros used by the checker file.
`ifndef REACHABLE_EVENT_CHAIN_DP_MACROS_SVH
`define REACHABLE_EVENT_CHAIN_DP_MACROS_SVH

// Check on every clock edge outside reset.
`define RECDP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check on every clock edge, reset included.
`define RECDP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

### hdl/recdp_pkg.sv
package recdp_pkg;

  localparam int unsigned DEF_MAX_EVENTS = 256;
  localparam int unsigned DEF_COORD_BITS = 16;

  localparam int unsigned IDX_OUT_W   = 8;
  localparam int unsigned LEN_OUT_W   = 9;
  localparam int unsigned OUT_FIELD_W = IDX_OUT_W + LEN_OUT_W + 1 + IDX_OUT_W;
  localparam int unsigned OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;

  typedef enum logic [2:0] {
    SCAN_IDLE,
    SCAN_READ,
    SCAN_LAST,
    SCAN_WRITE,
    SCAN_EMIT
  } scan_state_e;

  typedef struct packed {
    logic                 overflow;
    logic [IDX_OUT_W-1:0] predecessor;
    logic                 has_predecessor;
    logic [LEN_OUT_W-1:0] best_length;
    logic [IDX_OUT_W-1:0] event_index;
  } res_t;

endpackage

### hdl/recdp_store.sv
module recdp_store import recdp_pkg::*; #(
  parameter int unsigned DEPTH      = DEF_MAX_EVENTS,
  parameter int unsigned COORD_BITS = DEF_COORD_BITS,
  parameter int unsigned LEN_W      = $clog2(DEF_MAX_EVENTS) + 1
) (
  input  logic                     clk_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [COORD_BITS-1:0]    rd_coord_o,
  output logic [LEN_W-1:0]         rd_len_o,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [COORD_BITS-1:0]    wr_coord_i,
  input  logic [LEN_W-1:0]         wr_len_i
);

  logic [COORD_BITS-1:0] coord_mem [DEPTH];
  logic [LEN_W-1:0]      len_mem   [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      coord_mem[wr_addr_i] <= wr_coord_i;
      len_mem[wr_addr_i]   <= wr_len_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_coord_o <= coord_mem[rd_addr_i];
      rd_len_o   <= len_mem[rd_addr_i];
    end
  end

endmodule

### hdl/recdp_scan.sv
module recdp_scan import recdp_pkg::*; #(
  parameter int unsigned MAX_EVENTS = DEF_MAX_EVENTS,
  parameter int unsigned COORD_BITS = DEF_COORD_BITS
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [COORD_BITS-1:0]         in_coord_i,
  input  logic                          in_restart_i,
  output logic                          rd_en_o,
  output logic [$clog2(MAX_EVENTS)-1:0] rd_addr_o,
  input  logic [COORD_BITS-1:0]         rd_coord_i,
  input  logic [$clog2(MAX_EVENTS):0]   rd_len_i,
  output logic                          wr_en_o,
  output logic [$clog2(MAX_EVENTS)-1:0] wr_addr_o,
  output logic [COORD_BITS-1:0]         wr_coord_o,
  output logic [$clog2(MAX_EVENTS):0]   wr_len_o,
  output logic                          res_valid_o,
  input  logic                          res_ready_i,
  output res_t                          res_o
);

  localparam int unsigned IDX_W = $clog2(MAX_EVENTS);
  localparam int unsigned CNT_W = IDX_W + 1;
  localparam int unsigned LEN_W = IDX_W + 1;
  localparam int unsigned DW    = COORD_BITS + 1;
  localparam int unsigned CMP_W = (DW > IDX_W) ? DW : IDX_W;

  scan_state_e state_q, state_d;
  logic [CNT_W-1:0]      count_q, count_d;
  logic                  cmp_vld_q;
  logic [IDX_W-1:0]      i_q, ja_q, cmp_j_q, pred_q;
  logic [COORD_BITS-1:0] coord_q;
  logic [LEN_W-1:0]      best_q;
  logic                  found_q, ovf_q;

  logic                  accept;
  logic [CNT_W-1:0]      start_cnt;
  logic                  start_ovf;
  logic [DW-1:0]         diff, mag;
  logic [IDX_W-1:0]      gap;
  logic                  hit, take;
  logic [LEN_W-1:0]      len_new;

  assign accept    = in_valid_i && in_ready_o;
  assign start_cnt = in_restart_i ? '0 : count_q;
  assign start_ovf = start_cnt >= CNT_W'(MAX_EVENTS);

  // Distance test against the entry read last cycle.
  assign diff = {coord_q[COORD_BITS-1], coord_q} - {rd_coord_i[COORD_BITS-1], rd_coord_i};
  assign mag  = diff[DW-1] ? (~diff + DW'(1)) : diff;
  assign gap  = i_q - cmp_j_q;
  assign hit  = CMP_W'(mag) <= CMP_W'(gap);
  // Later entries win ties.
  assign take = cmp_vld_q && hit && (!found_q || (rd_len_i >= best_q));

  assign len_new = best_q + LEN_W'(1);

  assign rd_addr_o  = ja_q;
  assign wr_addr_o  = i_q;
  assign wr_coord_o = coord_q;
  assign wr_len_o   = len_new;

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    in_ready_o  = 1'b0;
    rd_en_o     = 1'b0;
    wr_en_o     = 1'b0;
    res_valid_o = 1'b0;
    unique case (state_q)
      SCAN_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          priority if (start_ovf) begin
            state_d = SCAN_EMIT;
          end else if (start_cnt == '0) begin
            state_d = SCAN_WRITE;
          end else begin
            state_d = SCAN_READ;
          end
        end
      end
      SCAN_READ: begin
        rd_en_o = 1'b1;
        if (IDX_W'(ja_q + IDX_W'(1)) == i_q) begin
          state_d = SCAN_LAST;
        end
      end
      SCAN_LAST: begin
        state_d = SCAN_WRITE;
      end
      SCAN_WRITE: begin
        wr_en_o = 1'b1;
        count_d = {1'b0, i_q} + CNT_W'(1);
        state_d = SCAN_EMIT;
      end
      SCAN_EMIT: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = SCAN_IDLE;
        end
      end
      default: begin
        state_d = SCAN_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= SCAN_IDLE;
      count_q   <= '0;
      cmp_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      cmp_vld_q <= rd_en_o;
    end
  end

  always_ff @(posedge clk_i) begin
    cmp_j_q <= ja_q;
    if (accept) begin
      coord_q <= in_coord_i;
      i_q     <= start_cnt[IDX_W-1:0];
      ovf_q   <= start_ovf;
      ja_q    <= '0;
      best_q  <= '0;
      pred_q  <= '0;
      found_q <= 1'b0;
    end else begin
      if (rd_en_o) begin
        ja_q <= ja_q + IDX_W'(1);
      end
      if (take) begin
        best_q  <= rd_len_i;
        pred_q  <= cmp_j_q;
        found_q <= 1'b1;
      end
    end
  end

  always_comb begin
    res_o = '0;
    if (ovf_q) begin
      res_o.overflow = 1'b1;
    end else begin
      res_o.event_index     = IDX_OUT_W'(i_q);
      res_o.best_length     = LEN_OUT_W'(len_new);
      res_o.has_predecessor = found_q;
      res_o.predecessor     = found_q ? IDX_OUT_W'(pred_q) : '0;
    end
  end

endmodule

### hdl/reachable_event_chain_dp.sv
// Longest compatible event chain. Each request carries one event coordinate
// (s_axis_tdata, sign-extended from bit COORD_BITS-1) and a restart flag
// (s_axis_tuser) that empties the history before the event is handled. The
// block answers each request with exactly one result: the event's index, the
// longest chain ending at it, and the earlier event that gives that chain
// (ties go to the latest one). An earlier event j qualifies when
// |C[i] - C[j]| <= i - j. Once MAX_EVENTS events are stored, further events
// are flagged with overflow on m_axis_tuser, carry zero data and are not
// stored until the next restart. From request to result, the history scan
// reads one stored event per cycle from the history memory, followed by the
// last compare, the write-back, the hand-off to the output register and the
// output register itself.
// The first event of a sequence skips the scan and overflowed events also
// skip the write-back.
// The output register lets the next request start while a result waits.
// The stores need no clearing pass: only entries below the event count
// are read, and each was written earlier in the same sequence.
module reachable_event_chain_dp import recdp_pkg::*; #(
  parameter int unsigned MAX_EVENTS = DEF_MAX_EVENTS,
  parameter int unsigned COORD_BITS = DEF_COORD_BITS
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // coordinate [COORD_BITS-1:0], zero pad above
  input  logic [((COORD_BITS+7)/8)*8-1:0]     s_axis_tdata,
  // restart
  input  logic                                s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // event_index [7:0], best_length [16:8], has_predecessor [17],
  // predecessor [25:18], zero pad above
  output logic [OUT_TDATA_W-1:0]              m_axis_tdata,
  // overflow
  output logic                                m_axis_tuser
);

  localparam int unsigned IDX_W = $clog2(MAX_EVENTS);
  localparam int unsigned LEN_W = IDX_W + 1;

  logic                  rd_en, wr_en;
  logic [IDX_W-1:0]      rd_addr, wr_addr;
  logic [COORD_BITS-1:0] rd_coord, wr_coord;
  logic [LEN_W-1:0]      rd_len, wr_len;
  logic                  res_valid, res_ready;
  res_t                  res;

  logic                  out_valid_q;
  res_t                  out_q;

  // Scan sequencer: one history read per cycle, best tracked on the fly.
  recdp_scan #(
    .MAX_EVENTS (MAX_EVENTS),
    .COORD_BITS (COORD_BITS)
  ) u_scan (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_coord_i   (s_axis_tdata[COORD_BITS-1:0]),
    .in_restart_i (s_axis_tuser),
    .rd_en_o      (rd_en),
    .rd_addr_o    (rd_addr),
    .rd_coord_i   (rd_coord),
    .rd_len_i     (rd_len),
    .wr_en_o      (wr_en),
    .wr_addr_o    (wr_addr),
    .wr_coord_o   (wr_coord),
    .wr_len_o     (wr_len),
    .res_valid_o  (res_valid),
    .res_ready_i  (res_ready),
    .res_o        (res)
  );

  // History of coordinates and chain lengths. The write-back of an event
  // lands before the next request can issue any read, so no forwarding.
  recdp_store #(
    .DEPTH      (MAX_EVENTS),
    .COORD_BITS (COORD_BITS),
    .LEN_W      (LEN_W)
  ) u_store (
    .clk_i      (clk_i),
    .rd_en_i    (rd_en),
    .rd_addr_i  (rd_addr),
    .rd_coord_o (rd_coord),
    .rd_len_o   (rd_len),
    .wr_en_i    (wr_en),
    .wr_addr_i  (wr_addr),
    .wr_coord_i (wr_coord),
    .wr_len_i   (wr_len)
  );

  // Output register: take a new result when empty or being drained.
  assign res_ready = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_q.overflow;
  assign m_axis_tdata  = {{(OUT_TDATA_W-OUT_FIELD_W){1'b0}}, out_q.predecessor,
                          out_q.has_predecessor, out_q.best_length, out_q.event_index};

endmodule

### hdl/recdp_checker.sv
`include "reachable_event_chain_dp_macros.svh"

module recdp_checker import recdp_pkg::*; #(
  parameter int unsigned MAX_EVENTS = DEF_MAX_EVENTS
) (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input logic                   m_axis_tuser
);

  localparam bit WIDE = MAX_EVENTS > (1 << IDX_OUT_W);

  `RECDP_ASSERT_ALWAYS(a_quiet_in_reset, !rst_ni |-> !m_axis_tvalid, "result valid in reset")
  `RECDP_ASSERT(a_hold_stalled, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled result changed")
  `RECDP_ASSERT(a_overflow_zero, m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0, "overflow result carries data")
  `RECDP_ASSERT(a_no_pred_len1, m_axis_tvalid && !m_axis_tuser && !m_axis_tdata[17] |-> m_axis_tdata[16:8] == 9'd1 && m_axis_tdata[25:18] == 8'd0, "lone event not length one")
  `RECDP_ASSERT(a_pred_earlier, WIDE || !(m_axis_tvalid && !m_axis_tuser && m_axis_tdata[17]) || (m_axis_tdata[25:18] < m_axis_tdata[7:0] && m_axis_tdata[16:8] > 9'd1), "predecessor not earlier")

endmodule

bind reachable_event_chain_dp recdp_checker #(
  .MAX_EVENTS (MAX_EVENTS)
) u_recdp_checker (.*);
